// ----- rtl/core/lams_pkg.sv -----
`timescale 1ns / 1ps

package lams_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int LABEL_BITS   = 16;
    localparam int SLOT_BITS    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] REQ_ADD_VERTEX = 2'd0;
    localparam logic [1:0] REQ_ADD_EDGE   = 2'd1;
    localparam logic [1:0] REQ_QUERY      = 2'd2;
    localparam logic [1:0] REQ_ROUTE      = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] label_a;
        logic [15:0] label_b;
        logic        route_first;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       adjacent;
        logic       route_ok;
    } rsp_t;

    typedef logic [LABEL_BITS-1:0] label_t;
    typedef label_t [MAX_VERTICES-1:0] label_array_t;
    typedef logic [MAX_VERTICES-1:0] row_t;

    typedef struct packed {
        logic                 found;
        logic [SLOT_BITS-1:0] slot;
    } lookup_t;

    // lowest occupied slot holding the label; label zero never matches
    function automatic lookup_t find_slot(
        input label_t                label,
        input label_array_t          labels,
        input logic [COUNT_BITS-1:0] count
    );
        lookup_t r;
        r = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if ((label != '0) && (COUNT_BITS'(i) < count) && (labels[i] == label))
            begin
                r.found = 1'b1;
                r.slot  = SLOT_BITS'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/labelled_adjacency_matrix_store_core.sv -----
`timescale 1ns / 1ps
// Labelled graph store with a directed adjacency bit matrix.
// Request channel: req_valid / req_stall / req. A transfer carries one
// request: add vertex, add edge, adjacency query or route element.
// Response channel: rsp_valid / rsp_stall / rsp. Every request gives
// exactly one response (status, adjacent, route_ok), in request order.
// Timing: when a request is taken, both labels are compared against all
// slots in parallel and the edge rows of both slots are read from the row
// memory into registers. In the execute state that follows, the rows are
// checked or the updated row is written back and the response register is
// loaded. The next request is taken once the response is in the output
// register, so a request is not taken before the previous one has finished.
// When the receiver stalls, the response is held and a finished request
// waits in the execute state until the output register is free.
// Reset empties the vertex table, marks every edge row as empty through
// per-row valid flags (no clearing pass), clears the previous route label
// and sets route_ok.
module labelled_adjacency_matrix_store_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lams_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lams_pkg::rsp_t rsp
);
    import lams_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    req_t                  req_reg;
    lookup_t               look_a_reg;
    lookup_t               look_b_reg;
    lookup_t               look_a;
    lookup_t               look_b;
    label_t                label_a_in;
    label_t                label_b_in;
    label_array_t          labels_reg;
    logic [COUNT_BITS-1:0] count_reg;
    label_t                prev_label_reg;
    logic                  route_good_reg;
    logic                  route_good_next;
    row_t                  row_valid_reg;
    row_t                  edge_mem [MAX_VERTICES];
    row_t                  rd_row_a_reg;
    row_t                  rd_row_b_reg;
    logic                  rd_val_a_reg;
    logic                  rd_val_b_reg;
    row_t                  row_a;
    row_t                  row_b;
    logic                  either;
    logic                  req_accept;
    logic                  exec_done;
    logic                  wr_en;
    row_t                  wr_row;
    logic                  add_vertex;
    logic                  route_upd;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // route elements pair the current label with the previous one
    assign label_a_in = req.label_a[LABEL_BITS-1:0];
    assign label_b_in = (req.req_type == REQ_ROUTE) ? prev_label_reg
                                                    : req.label_b[LABEL_BITS-1:0];
    assign look_a = find_slot(label_a_in, labels_reg, count_reg);
    assign look_b = find_slot(label_b_in, labels_reg, count_reg);

    assign exec_done = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);

    assign row_a  = rd_val_a_reg ? rd_row_a_reg : '0;
    assign row_b  = rd_val_b_reg ? rd_row_b_reg : '0;
    assign either = row_a[look_b_reg.slot] | row_b[look_a_reg.slot];

    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = STATUS_DONE;
        wr_en           = 1'b0;
        wr_row          = row_a | (row_t'(1) << look_b_reg.slot);
        add_vertex      = 1'b0;
        route_upd       = 1'b0;
        route_good_next = route_good_reg;
        case (req_reg.req_type)
            REQ_ADD_VERTEX:
            begin
                if (req_reg.label_a[LABEL_BITS-1:0] == '0)
                begin
                    rsp_next.status = STATUS_NOT_FOUND;
                end
                else if (count_reg >= COUNT_BITS'(MAX_VERTICES))
                begin
                    rsp_next.status = STATUS_FULL;
                end
                else
                begin
                    add_vertex = 1'b1;
                end
            end
            REQ_ADD_EDGE:
            begin
                if (look_a_reg.found && look_b_reg.found)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    rsp_next.status = STATUS_NOT_FOUND;
                end
            end
            REQ_QUERY:
            begin
                if (look_a_reg.found && look_b_reg.found)
                begin
                    rsp_next.adjacent = either;
                end
                else
                begin
                    rsp_next.status = STATUS_NOT_FOUND;
                end
            end
            REQ_ROUTE:
            begin
                route_upd = 1'b1;
                if (req_reg.route_first)
                begin
                    route_good_next = look_a_reg.found;
                end
                else
                begin
                    rsp_next.adjacent = look_a_reg.found && look_b_reg.found && either;
                    if (!rsp_next.adjacent)
                    begin
                        route_good_next = 1'b0;
                    end
                end
                if (!look_a_reg.found)
                begin
                    rsp_next.status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                rsp_next.status = STATUS_DONE;
            end
        endcase
        rsp_next.route_ok = route_good_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            prev_label_reg <= '0;
            route_good_reg <= 1'b1;
            row_valid_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_done)
            begin
                rsp_valid_reg <= 1'b1;
                if (add_vertex)
                begin
                    count_reg <= count_reg + COUNT_BITS'(1);
                end
                if (wr_en)
                begin
                    row_valid_reg[look_a_reg.slot] <= 1'b1;
                end
                if (route_upd)
                begin
                    prev_label_reg <= req_reg.label_a[LABEL_BITS-1:0];
                end
                route_good_reg <= route_good_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // label table, request and response payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg    <= req;
            look_a_reg <= look_a;
            look_b_reg <= look_b;
        end
        if (exec_done)
        begin
            rsp_reg <= rsp_next;
            if (add_vertex)
            begin
                labels_reg[count_reg[SLOT_BITS-1:0]] <= req_reg.label_a[LABEL_BITS-1:0];
            end
        end
    end

    // edge row memory: two read ports at request transfer, write back on completion
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            rd_row_a_reg <= edge_mem[look_a.slot];
            rd_row_b_reg <= edge_mem[look_b.slot];
            rd_val_a_reg <= row_valid_reg[look_a.slot];
            rd_val_b_reg <= row_valid_reg[look_b.slot];
        end
        if (exec_done && wr_en)
        begin
            edge_mem[look_a_reg.slot] <= wr_row;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == ST_EXEC)
        else $error("request transfer did not start execution");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(MAX_VERTICES))
        else $error("vertex count beyond table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_done |=> $stable(count_reg))
        else $error("vertex count changed outside completion");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_EXEC))
        else $error("response without an executing request");

    a_row_valid_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(row_valid_reg))
        else $error("edge row flags changed while idle");

endmodule

// ----- test/tb_labelled_adjacency_matrix_store_core.sv -----
`timescale 1ns / 1ps

class graph_scoreboard;
    lams_pkg::label_t slot_label [lams_pkg::MAX_VERTICES];
    lams_pkg::row_t   edge_row [lams_pkg::MAX_VERTICES];
    int unsigned      filled;
    lams_pkg::label_t last_route_label;
    logic             route_good;
    lams_pkg::rsp_t   expected_q [$];
    int unsigned      errors;

    function new();
        foreach (slot_label[i])
        begin
            slot_label[i] = '0;
            edge_row[i]   = '0;
        end
        filled           = 0;
        last_route_label = '0;
        route_good       = 1'b1;
        errors           = 0;
    endfunction

    function int lookup(input lams_pkg::label_t label);
        if (label == '0)
            return -1;
        for (int i = 0; i < filled; i++)
        begin
            if (slot_label[i] == label)
                return i;
        end
        return -1;
    endfunction

    function logic linked(input int x, input int y);
        return edge_row[x][y] | edge_row[y][x];
    endfunction

    function void note_request(input lams_pkg::req_t r);
        lams_pkg::rsp_t   e;
        lams_pkg::label_t la;
        lams_pkg::label_t lb;
        int               sa;
        int               sb;
        la = lams_pkg::label_t'(r.label_a);
        lb = lams_pkg::label_t'(r.label_b);
        e  = '0;
        e.status = lams_pkg::STATUS_DONE;
        case (r.req_type)
            lams_pkg::REQ_ADD_VERTEX:
            begin
                if (la == '0)
                    e.status = lams_pkg::STATUS_NOT_FOUND;
                else if (filled >= lams_pkg::MAX_VERTICES)
                    e.status = lams_pkg::STATUS_FULL;
                else
                begin
                    slot_label[filled] = la;
                    filled++;
                end
            end
            lams_pkg::REQ_ADD_EDGE:
            begin
                sa = lookup(la);
                sb = lookup(lb);
                if (sa < 0 || sb < 0)
                    e.status = lams_pkg::STATUS_NOT_FOUND;
                else
                    edge_row[sa][sb] = 1'b1;
            end
            lams_pkg::REQ_QUERY:
            begin
                sa = lookup(la);
                sb = lookup(lb);
                if (sa < 0 || sb < 0)
                    e.status = lams_pkg::STATUS_NOT_FOUND;
                else
                    e.adjacent = linked(sa, sb);
            end
            default:
            begin
                sa = lookup(la);
                if (r.route_first)
                    route_good = (sa >= 0);
                else
                begin
                    sb = lookup(last_route_label);
                    if (sa >= 0 && sb >= 0)
                        e.adjacent = linked(sb, sa);
                    if (!e.adjacent)
                        route_good = 1'b0;
                end
                if (sa < 0)
                    e.status = lams_pkg::STATUS_NOT_FOUND;
                last_route_label = la;
            end
        endcase
        e.route_ok = route_good;
        expected_q.push_back(e);
    endfunction

    function void check_response(input lams_pkg::rsp_t got);
        lams_pkg::rsp_t e;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("response with nothing outstanding: status %0d adjacent %0b route_ok %0b",
                         got.status, got.adjacent, got.route_ok);
            return;
        end
        e = expected_q.pop_front();
        if (got.status !== e.status || got.adjacent !== e.adjacent
            || got.route_ok !== e.route_ok)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected status %0d adjacent %0b route_ok %0b, got status %0d adjacent %0b route_ok %0b",
                         e.status, e.adjacent, e.route_ok,
                         got.status, got.adjacent, got.route_ok);
        end
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function lams_pkg::label_t known_label();
        if (filled == 0)
            return lams_pkg::label_t'($urandom);
        return slot_label[$urandom_range(filled - 1)];
    endfunction

    // a label joined to the given one by an edge either way, when there is one
    function lams_pkg::label_t neighbour_of(input lams_pkg::label_t label);
        int cand [$];
        int s;
        s = lookup(label);
        if (s < 0)
            return known_label();
        for (int j = 0; j < filled; j++)
        begin
            if (linked(s, j))
                cand.push_back(j);
        end
        if (cand.size() == 0)
            return known_label();
        return slot_label[cand[$urandom_range(cand.size() - 1)]];
    endfunction
endclass

module tb_labelled_adjacency_matrix_store_core;
    import lams_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned sent_count     = 0;

    graph_scoreboard graph_sb = new();

    always #6 clk = ~clk;

    labelled_adjacency_matrix_store_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            graph_sb.check_response(rsp);
        rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_request(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        graph_sb.note_request(item);
        sent_count++;
    endtask

    task automatic send_fields(input logic [1:0] kind, input label_t la, input label_t lb,
                               input logic first);
        req_t item;
        item.req_type    = kind;
        item.label_a     = 16'(la);
        item.label_b     = 16'(lb);
        item.route_first = first;
        send_request(item);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (graph_sb.pending() != 0);
    endtask

    function automatic label_t pick_operand();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 75)
            return graph_sb.known_label();
        else if (p < 82)
            return '0;
        return label_t'($urandom);
    endfunction

    function automatic label_t pick_new_vertex();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 45)
            return label_t'($urandom);
        else if (p < 65)
            return graph_sb.known_label();
        else if (p < 75)
            return '0;
        return label_t'($urandom_range(1, 15));
    endfunction

    task automatic walk_route(input int unsigned len);
        label_t cur;
        cur = ($urandom_range(99) < 85) ? graph_sb.known_label() : pick_operand();
        send_fields(REQ_ROUTE, cur, label_t'($urandom), 1'b1);
        for (int unsigned k = 1; k < len; k++)
        begin
            cur = ($urandom_range(99) < 80) ? graph_sb.neighbour_of(cur) : pick_operand();
            send_fields(REQ_ROUTE, cur, label_t'($urandom), 1'b0);
        end
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned start;
        int unsigned p;
        label_t      a;
        start = sent_count;
        while (sent_count - start < n)
        begin
            p = $urandom_range(99);
            if (p < 8)
                send_fields(REQ_ADD_VERTEX, pick_new_vertex(), label_t'($urandom),
                            1'($urandom));
            else if (p < 43)
            begin
                a = pick_operand();
                send_fields(REQ_ADD_EDGE, a, ($urandom_range(9) == 0) ? a : pick_operand(),
                            1'($urandom));
            end
            else if (p < 63)
                send_fields(REQ_QUERY, pick_operand(), pick_operand(), 1'($urandom));
            else if (p < 93)
                walk_route($urandom_range(2, 7));
            else
                send_request(req_t'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(REQ_QUERY, 16'h0001, 16'h0002, 1'b0);
        send_fields(REQ_ROUTE, 16'h0000, 16'h0000, 1'b1);
        send_fields(REQ_ADD_VERTEX, 16'h0000, 16'hFFFF, 1'b0);
        send_fields(REQ_ADD_VERTEX, 16'hFFFF, 16'h0000, 1'b0);
        send_fields(REQ_ADD_VERTEX, 16'h0001, 16'h0000, 1'b0);
        send_fields(REQ_ADD_VERTEX, 16'hFFFF, 16'h0000, 1'b0);
        send_fields(REQ_ADD_VERTEX, 16'h8000, 16'h0000, 1'b0);
        send_fields(REQ_ADD_EDGE, 16'hFFFF, 16'h0001, 1'b0);
        send_fields(REQ_ADD_EDGE, 16'h0001, 16'h0001, 1'b0);
        send_fields(REQ_ADD_EDGE, 16'h1234, 16'h0001, 1'b0);
        send_fields(REQ_ADD_EDGE, 16'h0001, 16'h0000, 1'b0);
        send_fields(REQ_QUERY, 16'h0001, 16'hFFFF, 1'b0);
        send_fields(REQ_QUERY, 16'hFFFF, 16'h8000, 1'b0);
        send_fields(REQ_QUERY, 16'h0001, 16'h0001, 1'b0);
        send_fields(REQ_QUERY, 16'h0001, 16'h5555, 1'b0);
        send_fields(REQ_ROUTE, 16'hFFFF, 16'h0000, 1'b1);
        send_fields(REQ_ROUTE, 16'h0001, 16'h0000, 1'b0);
        send_fields(REQ_ROUTE, 16'h0001, 16'h0000, 1'b0);
        send_fields(REQ_ROUTE, 16'h8000, 16'h0000, 1'b0);
        send_fields(REQ_ROUTE, 16'h8000, 16'h0000, 1'b1);
        send_fields(REQ_ROUTE, 16'h5555, 16'h0000, 1'b0);
        send_fields(REQ_ROUTE, 16'h0001, 16'h0000, 1'b0);
        drain();

        // sender mostly busy, receiver mostly stalling
        send_idle_pct  = 16;
        recv_stall_pct = 79;
        run_random(330);
        drain();

        send_idle_pct  = 79;
        recv_stall_pct = 16;
        run_random(330);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(340);
        drain();
        repeat (8) @(posedge clk);

        if (graph_sb.errors == 0 && graph_sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
